// ----- rtl/core/pixel_clock_divider_search_defines.svh -----
// assertion macros for the pixel clock divider search
`ifndef PIXEL_CLOCK_DIVIDER_SEARCH_DEFINES_SVH
`define PIXEL_CLOCK_DIVIDER_SEARCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCDS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PCDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pcds_pkg.sv -----
package pcds_pkg;

  // field widths
  localparam int unsigned TargetW   = 20;
  localparam int unsigned DividerW  = 7;
  localparam int unsigned MultW     = 7;
  localparam int unsigned ShortW    = 28;

  // search range
  localparam int unsigned MaxDivider = 127;
  localparam int unsigned Ch0MinDiv  = 6;
  localparam int unsigned Ch1MinDiv  = 1;
  localparam int unsigned Ch1MaxDiv  = 15;
  localparam int unsigned DivW       = $clog2(MaxDivider + 1);

  // pll step and multiplier window
  localparam int unsigned StepKhz = 6000;
  localparam int unsigned MinMult = 9;
  localparam int unsigned MaxMult = 127;
  localparam logic [ShortW-1:0] NoFit = 28'hFFF_FFFF;

  // datapath widths
  localparam int unsigned ProdW = DivW + TargetW;
  localparam int unsigned RemW  = $clog2(StepKhz);
  localparam int unsigned QW    = $clog2(StepKhz * (MaxMult + 1));
  localparam int unsigned CntW  = $clog2(QW + 1);

  // product window for a multiplier inside MinMult..MaxMult
  localparam logic [ProdW-1:0] LoProd = ProdW'(MinMult * StepKhz);
  localparam logic [ProdW-1:0] HiProd = ProdW'((MaxMult + 1) * StepKhz);

  typedef struct packed {
    logic               channel_select;
    logic [TargetW-1:0] target_khz;
  } req_t;

  typedef struct packed {
    logic [DividerW-1:0] divider;
    logic [MultW-1:0]    multiplier;
    logic                double_clock;
    logic                found;
    logic [ShortW-1:0]   shortfall_khz;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StDiv1,
    StMul2,
    StDiv2,
    StCmp,
    StDone
  } pcds_state_e;

endpackage

// ----- rtl/core/pixel_clock_divider_search.sv -----
// pixel clock divider search: a request (start high while busy is low) carries a
// channel select and a target dot clock in kHz. channel 0 tries output dividers
// 6..127, channel 1 tries 1..15, in increasing order. for each divider m the
// multiplier n = floor(m*target/6000) is formed; dividers whose n falls outside
// 9..127 are skipped after a single range test on the product m*target, which
// takes the multiply and the range test. a divider in range takes the
// multiply, the range test, 7 steps of the shared restoring divider for n, one
// constant multiply, 20 divider steps for the achieved rate 6000*n/m, and one
// compare. the shared divider, one quotient bit per cycle, sets the pace; at most
// 119 dividers of channel 0 (9..127) can be in range for one target. busy stays
// high from the request being taken through the result, and the next request
// can be taken in the cycle after the result. the result is shown for exactly
// one cycle with result_valid_o high and cannot be held off, so the receiver
// must take it then. ties keep the smaller divider; when nothing fits, divider,
// multiplier and double_clock are zero and the shortfall reads 0x0FFFFFFF.
`include "pixel_clock_divider_search_defines.svh"

module pixel_clock_divider_search (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  pcds_pkg::req_t  req_i,
  output logic            busy,
  output logic            result_valid_o,
  output pcds_pkg::res_t  result_o
);
  import pcds_pkg::*;

  // sequencer state
  pcds_state_e state_q, state_d;

  // candidate loop
  logic [DivW-1:0]    m_q, m_d;
  logic [DivW-1:0]    hi_q, hi_d;
  logic [TargetW-1:0] target_q, target_d;
  logic [ProdW-1:0]   prod_q, prod_d;

  // shared divider: partial remainder, dividend/quotient shift register, divisor
  logic [RemW-1:0] rem_q, rem_d;
  logic [QW-1:0]   dq_q, dq_d;
  logic [RemW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MultW-1:0] n_q, n_d;

  // best candidate so far
  logic [DivW-1:0]   best_m_q, best_m_d;
  logic [MultW-1:0]  best_n_q, best_n_d;
  logic [ShortW-1:0] min_short_q, min_short_d;
  logic              found_q, found_d;

  logic              in_range;
  logic              last_div;
  logic [RemW+1:0]   trial;
  logic              qbit;
  logic [TargetW-1:0] diff;

  // legal shapes of a no-fit and of a found result
  logic              nofit_ok;
  logic              found_ok;

  // n within 9..127 exactly when the product lies in this window
  assign in_range = (prod_q >= LoProd) && (prod_q < HiProd);
  assign last_div = (m_q == hi_q);

  // one restoring step: bring in the next dividend bit, try the subtraction
  assign trial = {1'b0, rem_q, dq_q[QW-1]} - {2'b00, dvs_q};
  assign qbit  = ~trial[RemW+1];

  // achieved rate never exceeds the target
  assign diff = target_q - TargetW'(dq_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StMul;
        end
      end
      StMul: state_d = StCheck;
      StCheck: begin
        if (in_range) begin
          state_d = StDiv1;
        end else if (last_div) begin
          state_d = StDone;
        end else begin
          state_d = StMul;
        end
      end
      StDiv1: begin
        if (cnt_q == CntW'(1)) begin
          state_d = StMul2;
        end
      end
      StMul2: state_d = StDiv2;
      StDiv2: begin
        if (cnt_q == CntW'(1)) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (last_div) begin
          state_d = StDone;
        end else begin
          state_d = StMul;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath
  always_comb begin
    m_d         = m_q;
    hi_d        = hi_q;
    target_d    = target_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    best_m_d    = best_m_q;
    best_n_d    = best_n_q;
    min_short_d = min_short_q;
    found_d     = found_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          target_d    = req_i.target_khz;
          m_d         = req_i.channel_select ? DivW'(Ch1MinDiv) : DivW'(Ch0MinDiv);
          hi_d        = req_i.channel_select ? DivW'(Ch1MaxDiv) : DivW'(MaxDivider);
          best_m_d    = '0;
          best_n_d    = '0;
          min_short_d = NoFit;
          found_d     = 1'b0;
        end
      end
      StMul: begin
        prod_d = m_q * target_q;
      end
      StCheck: begin
        if (in_range) begin
          // quotient fits in MultW bits, so the upper part is already below 6000
          rem_d = RemW'(prod_q >> MultW);
          dq_d  = {prod_q[MultW-1:0], {(QW - MultW){1'b0}}};
          dvs_d = RemW'(StepKhz);
          cnt_d = CntW'(MultW);
        end else if (!last_div) begin
          m_d = m_q + DivW'(1);
        end
      end
      StDiv1, StDiv2: begin
        rem_d = qbit ? trial[RemW-1:0] : {rem_q[RemW-2:0], dq_q[QW-1]};
        dq_d  = {dq_q[QW-2:0], qbit};
        cnt_d = cnt_q - CntW'(1);
      end
      StMul2: begin
        n_d   = dq_q[MultW-1:0];
        rem_d = '0;
        dq_d  = QW'(dq_q[MultW-1:0] * StepKhz);
        dvs_d = RemW'(m_q);
        cnt_d = CntW'(QW);
      end
      StCmp: begin
        // strict compare keeps the first divider on a tie
        if (ShortW'(diff) < min_short_q) begin
          min_short_d = ShortW'(diff);
          best_m_d    = m_q;
          best_n_d    = n_q;
          found_d     = 1'b1;
        end
        if (!last_div) begin
          m_d = m_q + DivW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy                   = (state_q != StIdle);
    result_valid_o         = (state_q == StDone);
    result_o.divider       = DividerW'(best_m_q);
    result_o.multiplier    = best_n_q;
    result_o.double_clock  = found_q;
    result_o.found         = found_q;
    result_o.shortfall_khz = min_short_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q         <= m_d;
    hi_q        <= hi_d;
    target_q    <= target_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    dq_q        <= dq_d;
    dvs_q       <= dvs_d;
    cnt_q       <= cnt_d;
    n_q         <= n_d;
    best_m_q    <= best_m_d;
    best_n_q    <= best_n_d;
    min_short_q <= min_short_d;
    found_q     <= found_d;
  end

  assign nofit_ok = (result_o.shortfall_khz == NoFit) && (result_o.divider == '0)
                    && (result_o.multiplier == '0);
  assign found_ok = (result_o.multiplier >= MultW'(MinMult)) && (result_o.divider != '0);

  // checks
  `PCDS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request taken but not busy")
  `PCDS_ASSERT_NEXT(a_res_idle, result_valid_o, !busy && !result_valid_o, "stuck after result")
  `PCDS_ASSERT_NOW(a_nofit, result_valid_o && !result_o.found, nofit_ok, "bad no-fit result")
  `PCDS_ASSERT_NOW(a_found, result_valid_o && result_o.found, found_ok, "found outside window")

endmodule

// ----- tb/pixel_clock_divider_search_tb.sv -----
`timescale 1ns / 100ps

module pixel_clock_divider_search_tb;
  import pcds_pkg::*;

  // shortfall reported when no divider fits
  localparam logic [ShortW-1:0] NO_FIT_KHZ = 28'hFFF_FFFF;
  localparam res_t NO_FIT_RES = '{divider: '0, multiplier: '0, double_clock: 1'b0,
                                  found: 1'b0, shortfall_khz: NO_FIT_KHZ};

  localparam int unsigned RANDOM_REQS  = 118;
  localparam int unsigned DRAIN_CYCLES = 64;
  // watchdog limit for the whole run, several times what the slowest run takes
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    logic               chan;
    logic [TargetW-1:0] target;
    bit                 typed;
    res_t               want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic result_valid_o;
  res_t result_o;

  // settings still owed by the block, oldest first
  res_t expected_settings[$];

  int unsigned     mismatch_cnt;
  int unsigned     dir_sent;
  int unsigned     rand_sent;
  int unsigned     results_seen;
  int unsigned     found_seen;
  longint unsigned cycle_cnt;

  // directed requests: extremes of both channels, edges of the multiplier
  // window, exact hits that tie at a doubled divider, and a few real modes
  dir_row_t dir_tab [DIR_ROWS] = '{
    // zero and full-scale targets fit nowhere
    '{1'b0, 20'd0,       1'b1, NO_FIT_RES},
    '{1'b1, 20'd0,       1'b1, NO_FIT_RES},
    '{1'b0, 20'd1048575, 1'b1, NO_FIT_RES},
    '{1'b1, 20'd1048575, 1'b1, NO_FIT_RES},
    // exact hit at the first divider, tied again at twice the divider
    '{1'b0, 20'd54000,   1'b1, res_t'{7'd6, 7'd54, 1'b1, 1'b1, 28'd0}},
    '{1'b1, 20'd54000,   1'b1, res_t'{7'd1, 7'd9, 1'b1, 1'b1, 28'd0}},
    // lowest target channel 1 can reach, and just below it
    '{1'b1, 20'd3600,    1'b1, res_t'{7'd15, 7'd9, 1'b1, 1'b1, 28'd0}},
    '{1'b1, 20'd3599,    1'b1, NO_FIT_RES},
    // lowest target channel 0 can reach, and just below it
    '{1'b0, 20'd425,     1'b1, NO_FIT_RES},
    '{1'b0, 20'd426,     1'b0, '0},
    // top of the multiplier window on channel 0
    '{1'b0, 20'd127000,  1'b1, res_t'{7'd6, 7'd127, 1'b1, 1'b1, 28'd0}},
    '{1'b0, 20'd127999,  1'b1, res_t'{7'd6, 7'd127, 1'b1, 1'b1, 28'd999}},
    '{1'b0, 20'd128000,  1'b1, NO_FIT_RES},
    // top of the multiplier window on channel 1
    '{1'b1, 20'd762000,  1'b1, res_t'{7'd1, 7'd127, 1'b1, 1'b1, 28'd0}},
    '{1'b1, 20'd762001,  1'b0, '0},
    // common video modes and a few other targets
    '{1'b0, 20'd148500,  1'b0, '0},
    '{1'b1, 20'd148500,  1'b0, '0},
    '{1'b0, 20'd25175,   1'b0, '0},
    '{1'b1, 20'd65000,   1'b0, '0},
    '{1'b0, 20'd33333,   1'b0, '0},
    '{1'b1, 20'd524288,  1'b0, '0},
    '{1'b0, 20'd65535,   1'b0, '0}
  };

  pixel_clock_divider_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // best divider for a request: first m with the strictly smallest shortfall
  function automatic res_t search_divider(req_t r);
    longint unsigned lo, hi, m, n, rate, diff, min_short;
    res_t best;
    lo = r.channel_select ? Ch1MinDiv : Ch0MinDiv;
    hi = r.channel_select ? Ch1MaxDiv : MaxDivider;
    best = '0;
    min_short = NO_FIT_KHZ;
    for (m = lo; m <= hi; m++) begin
      n = (m * r.target_khz) / StepKhz;
      if (n >= MinMult && n <= MaxMult) begin
        rate = (StepKhz * n) / m;
        // rate never exceeds the target, so no wrap here
        diff = r.target_khz - rate;
        if (diff < min_short) begin
          min_short         = diff;
          best.divider      = DividerW'(m);
          best.multiplier   = MultW'(n);
          best.double_clock = 1'b1;
          best.found        = 1'b1;
        end
      end
    end
    best.shortfall_khz = ShortW'(min_short);
    return best;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // drive one request from the falling edge and hold it until taken;
  // start is left high so a following request without a gap stays back to back
  task automatic issue_request(req_t r, res_t want, int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_settings.push_back(want);
  endtask

  // result monitor: each strobe is taken at the edge that closes its cycle
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_settings.size() == 0) begin
        flag_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_settings.pop_front();
        check_field("divider", result_o.divider, want.divider);
        check_field("multiplier", result_o.multiplier, want.multiplier);
        check_field("double_clock", result_o.double_clock, want.double_clock);
        check_field("found", result_o.found, want.found);
        check_field("shortfall_khz", result_o.shortfall_khz, want.shortfall_khz);
        if (want.found) begin
          found_seen++;
        end
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_settings.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    req_t        r;
    res_t        want;
    int unsigned idle_pct;
    int unsigned gap;
    int unsigned pick;
    int unsigned m;
    int unsigned n;

    mismatch_cnt = 0;
    dir_sent     = 0;
    rand_sent    = 0;
    results_seen = 0;
    found_seen   = 0;
    cycle_cnt    = 0;
    start        = 1'b0;
    req_i        = '0;
    rst_ni       = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, back to back
    foreach (dir_tab[i]) begin
      r.channel_select = dir_tab[i].chan;
      r.target_khz     = dir_tab[i].target;
      want = dir_tab[i].typed ? dir_tab[i].want : search_divider(r);
      issue_request(r, want, 0);
      dir_sent++;
    end

    // random requests in four phases of sender idling; the receiver
    // cannot hold results off, so its phases reduce to no idling
    for (int unsigned i = 0; i < RANDOM_REQS; i++) begin
      case ((i * 4) / RANDOM_REQS)
        0:       idle_pct = 0;
        1:       idle_pct = 52;
        2:       idle_pct = 0;
        default: idle_pct = 32;
      endcase
      r.channel_select = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // targets inside the reachable window of the channel
        r.target_khz = r.channel_select ? TargetW'($urandom_range(3600, 767999))
                                        : TargetW'($urandom_range(426, 127999));
      end else if (pick < 85) begin
        // near an exact rate, which tends to give ties and zero shortfall
        m = r.channel_select ? $urandom_range(Ch1MinDiv, Ch1MaxDiv)
                             : $urandom_range(Ch0MinDiv, MaxDivider);
        n = $urandom_range(MinMult, MaxMult);
        r.target_khz = TargetW'((StepKhz * n) / m + $urandom_range(0, 3));
      end else begin
        // anything the field allows, mostly no fit
        r.target_khz = TargetW'($urandom());
      end
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      issue_request(r, search_divider(r), gap);
      rand_sent++;
    end

    @(negedge clk_i);
    start = 1'b0;

    // drain, then give stray strobes a chance to show
    while (expected_settings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d directed and %0d random requests on both channels",
             dir_sent, rand_sent);
    $display("checked %0d results, %0d with a setting found, %0d mismatches",
             results_seen, found_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
